>>> sv/tlhm_pkg.sv
// Shared widths, types and enables for the trilinear hex map datapath.
package tlhm_pkg;

  // Field widths.
  localparam int VertW = 32;
  localparam int RefW  = 18;
  localparam int OutW  = 41;

  // Interpolator internals: a 42-bit difference split into a signed high part
  // and an unsigned low part so that each product stays narrow.
  localparam int DiffW  = OutW + 1;
  localparam int SplitW = 21;
  localparam int HiW    = DiffW - SplitW + RefW;
  localparam int LoW    = SplitW + 1 + RefW;

  // Pipeline depth: one operand stage and three interpolation levels of three.
  localparam int NumStages = 10;

  // Stream payload widths.
  localparam int InDataW  = 312;
  localparam int OutDataW = 288;

  typedef logic signed [VertW-1:0] tlhm_vert_t;
  typedef logic signed [RefW-1:0]  tlhm_ref_t;
  typedef logic signed [OutW-1:0]  tlhm_val_t;

  // Reference point and its in-cell flag, carried along the pipeline.
  typedef struct packed {
    tlhm_ref_t u;
    tlhm_ref_t v;
    tlhm_ref_t w;
    logic      in_cube;
  } tlhm_coord_t;

  // One interpolation operand pair.
  typedef struct packed {
    tlhm_val_t a;
    tlhm_val_t b;
  } tlhm_pair_t;

  // Stage enables of one interpolator.
  typedef struct packed {
    logic sub_en;
    logic mul_en;
    logic sum_en;
  } tlhm_lerp_en_t;

endpackage

>>> sv/tlhm_lerp.sv
// Three-stage linear interpolator: floor(a + (b - a) * r / 2^FRAC_BITS), saturated.
module tlhm_lerp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  tlhm_pkg::tlhm_lerp_en_t en_i,
  input  tlhm_pkg::tlhm_val_t   a_i,
  input  tlhm_pkg::tlhm_val_t   b_i,
  input  tlhm_pkg::tlhm_ref_t   r_i,
  output tlhm_pkg::tlhm_val_t   y_o
);

  localparam int OutW   = tlhm_pkg::OutW;
  localparam int DiffW  = tlhm_pkg::DiffW;
  localparam int SplitW = tlhm_pkg::SplitW;
  localparam int HiW    = tlhm_pkg::HiW;
  localparam int LoW    = tlhm_pkg::LoW;
  localparam int ProdW  = HiW + SplitW;
  localparam int AccW   = ((OutW + FRAC_BITS > ProdW) ? OutW + FRAC_BITS : ProdW) + 2;

  localparam logic signed [AccW-1:0] MaxV = {{(AccW-OutW+1){1'b0}}, {(OutW-1){1'b1}}};
  localparam logic signed [AccW-1:0] MinV = ~MaxV;

  logic signed [DiffW-1:0] d_q, d_d;
  tlhm_pkg::tlhm_val_t     a1_q, a2_q;
  tlhm_pkg::tlhm_ref_t     r_q;
  logic signed [HiW-1:0]   ph_q, ph_d;
  logic signed [LoW-1:0]   pl_q, pl_d;
  logic signed [AccW-1:0]  acc;
  logic signed [AccW-1:0]  shifted;
  tlhm_pkg::tlhm_val_t     y_q, y_d;

  // Difference of the end points; exact in one extra bit.
  assign d_d = DiffW'(b_i) - DiffW'(a_i);

  always_ff @(posedge clk_i) begin
    if (en_i.sub_en) begin
      d_q  <= d_d;
      a1_q <= a_i;
      r_q  <= r_i;
    end
  end

  // Two narrow partial products of the difference and the weight.
  assign ph_d = $signed(d_q[DiffW-1:SplitW]) * r_q;
  assign pl_d = $signed({1'b0, d_q[SplitW-1:0]}) * r_q;

  always_ff @(posedge clk_i) begin
    if (en_i.mul_en) begin
      ph_q <= ph_d;
      pl_q <= pl_d;
      a2_q <= a1_q;
    end
  end

  // Exact sum with the scaled start point, floor shift, then clamp.
  always_comb begin
    acc     = (AccW'(ph_q) <<< SplitW) + AccW'(pl_q) + (AccW'(a2_q) <<< FRAC_BITS);
    shifted = acc >>> FRAC_BITS;
    if (shifted > MaxV) begin
      y_d = MaxV[OutW-1:0];
    end else if (shifted < MinV) begin
      y_d = MinV[OutW-1:0];
    end else begin
      y_d = shifted[OutW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sum_en) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

>>> sv/trilinear_hex_map_with_derivatives.sv
// Top level: trilinear value, first and mixed derivatives of one hex cell component.
// Path: one operand stage, then three interpolation levels of three stages each.
// Throughput: one beat per cycle while the output is not stalled; every stage
// has its own valid bit and enable, so bubbles close up behind a stalled output.
// Reset clears only the valid bits; the datapath registers hold no reset value.
module trilinear_hex_map_with_derivatives #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // vert0..vert7 (32 bits each), ref_u, ref_v, ref_w (18 bits each), zero pad.
  input  logic [tlhm_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // mapped_value, deriv_u, deriv_v, deriv_w, deriv_uv, deriv_uw, deriv_vw
  // (41 bits each), inside_cell (1 bit).
  output logic [tlhm_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int NumStages = tlhm_pkg::NumStages;
  localparam int VertW     = tlhm_pkg::VertW;
  localparam int RefW      = tlhm_pkg::RefW;
  localparam int OutW      = tlhm_pkg::OutW;
  localparam int RefBase   = 8 * VertW;
  localparam int NumL1     = 13;
  localparam int NumL2     = 5;

  typedef enum logic [1:0] {
    AXIS_U,
    AXIS_V,
    AXIS_W
  } axis_e;

  // Weight axis of each first-level interpolation.
  localparam axis_e L1Axis [NumL1] = '{
    AXIS_U, AXIS_U, AXIS_U, AXIS_U, AXIS_V, AXIS_V, AXIS_U,
    AXIS_U, AXIS_U, AXIS_U, AXIS_W, AXIS_V, AXIS_U
  };
  // Weight axis of each second-level interpolation.
  localparam axis_e L2Axis [NumL2] = '{AXIS_V, AXIS_V, AXIS_W, AXIS_W, AXIS_V};

  function automatic tlhm_pkg::tlhm_ref_t pick(tlhm_pkg::tlhm_coord_t c, axis_e ax);
    tlhm_pkg::tlhm_ref_t r;
    case (ax)
      AXIS_U:  r = c.u;
      AXIS_V:  r = c.v;
      AXIS_W:  r = c.w;
      default: r = c.u;
    endcase
    return r;
  endfunction

  function automatic logic in_unit(tlhm_pkg::tlhm_ref_t r);
    return (r >= 0) && (int'(r) <= (1 << FRAC_BITS));
  endfunction

  // Per-stage enables: a stage moves when it is empty or the next one moves.
  logic [NumStages:0]   en;
  logic [NumStages-1:0] vld_q;

  always_comb begin
    en[NumStages] = m_axis_tready;
    for (int k = NumStages - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Unpack the input beat.
  tlhm_pkg::tlhm_vert_t  vx [8];
  tlhm_pkg::tlhm_coord_t coord_d;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      vx[i] = s_axis_tdata[VertW*i +: VertW];
    end
    coord_d.u       = s_axis_tdata[RefBase +: RefW];
    coord_d.v       = s_axis_tdata[RefBase + RefW +: RefW];
    coord_d.w       = s_axis_tdata[RefBase + 2*RefW +: RefW];
    coord_d.in_cube = in_unit(coord_d.u) && in_unit(coord_d.v) && in_unit(coord_d.w);
  end

  // First-level operands: corner values, edge differences and face sums.
  tlhm_pkg::tlhm_val_t  e [8];
  tlhm_pkg::tlhm_pair_t op_d [NumL1];
  tlhm_pkg::tlhm_pair_t op_q [NumL1];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      e[i] = OutW'(vx[i]);
    end
    op_d[0]  = '{a: e[0], b: e[1]};
    op_d[1]  = '{a: e[3], b: e[2]};
    op_d[2]  = '{a: e[4], b: e[5]};
    op_d[3]  = '{a: e[7], b: e[6]};
    op_d[4]  = '{a: e[1] - e[0], b: e[2] - e[3]};
    op_d[5]  = '{a: e[5] - e[4], b: e[6] - e[7]};
    op_d[6]  = '{a: e[3] - e[0], b: e[2] - e[1]};
    op_d[7]  = '{a: e[7] - e[4], b: e[6] - e[5]};
    op_d[8]  = '{a: e[4] - e[0], b: e[5] - e[1]};
    op_d[9]  = '{a: e[7] - e[3], b: e[6] - e[2]};
    op_d[10] = '{a: e[0] - e[1] + e[2] - e[3], b: e[4] - e[5] + e[6] - e[7]};
    op_d[11] = '{a: e[0] - e[1] - e[4] + e[5], b: e[3] - e[2] + e[6] - e[7]};
    op_d[12] = '{a: e[0] - e[3] - e[4] + e[7], b: e[1] - e[2] - e[5] + e[6]};
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int g = 0; g < NumL1; g++) begin
        op_q[g] <= op_d[g];
      end
    end
  end

  // The reference point travels with its beat through every stage.
  tlhm_pkg::tlhm_coord_t coord_q [NumStages];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      coord_q[0] <= coord_d;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        coord_q[k] <= coord_q[k-1];
      end
    end
  end

  tlhm_pkg::tlhm_lerp_en_t l1_en, l2_en, l3_en;
  assign l1_en = '{sub_en: en[1], mul_en: en[2], sum_en: en[3]};
  assign l2_en = '{sub_en: en[4], mul_en: en[5], sum_en: en[6]};
  assign l3_en = '{sub_en: en[7], mul_en: en[8], sum_en: en[9]};

  // First interpolation level.
  tlhm_pkg::tlhm_val_t l1_y [NumL1];

  for (genvar g = 0; g < NumL1; g++) begin : g_l1
    tlhm_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
      .clk_i (clk_i),
      .en_i  (l1_en),
      .a_i   (op_q[g].a),
      .b_i   (op_q[g].b),
      .r_i   (pick(coord_q[0], L1Axis[g])),
      .y_o   (l1_y[g])
    );
  end

  // Second interpolation level.
  tlhm_pkg::tlhm_pair_t l2_op [NumL2];
  tlhm_pkg::tlhm_val_t  l2_y [NumL2];

  always_comb begin
    l2_op[0] = '{a: l1_y[0], b: l1_y[1]};
    l2_op[1] = '{a: l1_y[2], b: l1_y[3]};
    l2_op[2] = '{a: l1_y[4], b: l1_y[5]};
    l2_op[3] = '{a: l1_y[6], b: l1_y[7]};
    l2_op[4] = '{a: l1_y[8], b: l1_y[9]};
  end

  for (genvar g = 0; g < NumL2; g++) begin : g_l2
    tlhm_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
      .clk_i (clk_i),
      .en_i  (l2_en),
      .a_i   (l2_op[g].a),
      .b_i   (l2_op[g].b),
      .r_i   (pick(coord_q[3], L2Axis[g])),
      .y_o   (l2_y[g])
    );
  end

  // Third level: the interpolated value itself.
  tlhm_pkg::tlhm_val_t l3_y;

  tlhm_lerp #(.FRAC_BITS(FRAC_BITS)) u_l3 (
    .clk_i (clk_i),
    .en_i  (l3_en),
    .a_i   (l2_y[0]),
    .b_i   (l2_y[1]),
    .r_i   (coord_q[6].w),
    .y_o   (l3_y)
  );

  // Mixed derivatives finish after one level and first derivatives after two;
  // they wait in delay registers until the value catches up.
  tlhm_pkg::tlhm_val_t mix_q [3][4:NumStages-1];
  tlhm_pkg::tlhm_val_t drv_q [3][7:NumStages-1];

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      if (en[4]) begin
        mix_q[j][4] <= l1_y[10 + j];
      end
      for (int k = 5; k < NumStages; k++) begin
        if (en[k]) begin
          mix_q[j][k] <= mix_q[j][k-1];
        end
      end
      if (en[7]) begin
        drv_q[j][7] <= l2_y[2 + j];
      end
      for (int k = 8; k < NumStages; k++) begin
        if (en[k]) begin
          drv_q[j][k] <= drv_q[j][k-1];
        end
      end
    end
  end

  // Pack the output beat.
  assign m_axis_tdata = {
    coord_q[NumStages-1].in_cube,
    mix_q[2][NumStages-1],
    mix_q[1][NumStages-1],
    mix_q[0][NumStages-1],
    drv_q[2][NumStages-1],
    drv_q[1][NumStages-1],
    drv_q[0][NumStages-1],
    l3_y
  };

endmodule

>>> sv/tlhm_checker.sv
// Port-level checks for the trilinear hex map, bound to its top level.
module tlhm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [tlhm_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int CntW = $clog2(tlhm_pkg::NumStages + 2);

  logic            in_beat, out_beat;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;
  assign cnt_d    = cnt_q + CntW'(in_beat) - CntW'(out_beat);

  // Beats inside the pipeline: accepted but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  // No result without a beat in flight.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> !m_axis_tvalid)
    else $error("output beat with nothing in flight");

  // The pipeline never holds more beats than it has stages.
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(tlhm_pkg::NumStages))
    else $error("more beats in flight than pipeline stages");

  // With the output register empty every stage can move, so input is taken.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the output is empty");

endmodule

bind trilinear_hex_map_with_derivatives tlhm_checker u_tlhm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> bench/testbench.sv
// Self-checking testbench for the trilinear hex map with derivatives.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FracBits = 16;
  localparam int PadW     = tlhm_pkg::InDataW - 8 * tlhm_pkg::VertW - 3 * tlhm_pkg::RefW;

  localparam logic signed [127:0] ValMax = (128'sd1 <<< (tlhm_pkg::OutW - 1)) - 128'sd1;
  localparam logic signed [127:0] ValMin = -(128'sd1 <<< (tlhm_pkg::OutW - 1));

  localparam tlhm_pkg::tlhm_vert_t VertMax = 32'sh7fff_ffff;
  localparam tlhm_pkg::tlhm_vert_t VertMin = 32'sh8000_0000;
  localparam tlhm_pkg::tlhm_ref_t  RefOne  = 18'sd65536;
  localparam tlhm_pkg::tlhm_ref_t  RefMax  = 18'sd131071;
  localparam tlhm_pkg::tlhm_ref_t  RefMin  = -18'sd131072;

  // One input beat; the first vertex sits in the lowest bits.
  typedef struct packed {
    tlhm_pkg::tlhm_ref_t                  w;
    tlhm_pkg::tlhm_ref_t                  v;
    tlhm_pkg::tlhm_ref_t                  u;
    logic [7:0][tlhm_pkg::VertW-1:0]      vert;
  } cell_sample_t;

  // One output beat; the mapped value sits in the lowest bits.
  typedef struct packed {
    logic                inside_cell;
    tlhm_pkg::tlhm_val_t deriv_vw;
    tlhm_pkg::tlhm_val_t deriv_uw;
    tlhm_pkg::tlhm_val_t deriv_uv;
    tlhm_pkg::tlhm_val_t deriv_w;
    tlhm_pkg::tlhm_val_t deriv_v;
    tlhm_pkg::tlhm_val_t deriv_u;
    tlhm_pkg::tlhm_val_t mapped_value;
  } cell_result_t;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [tlhm_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [tlhm_pkg::OutDataW-1:0] m_axis_tdata;

  cell_result_t expected_results[$];
  int           error_count   = 0;
  int           burst_left    = 0;
  bit           sender_gapless = 1'b0;
  int           hold_request  = 0;

  trilinear_hex_map_with_derivatives #(
    .FRAC_BITS(FracBits)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // Blend a toward b by r, floor the scaled sum and clamp to the output range.
  function automatic tlhm_pkg::tlhm_val_t interp(input logic signed [63:0] a,
                                                 input logic signed [63:0] b,
                                                 input tlhm_pkg::tlhm_ref_t r);
    logic signed [127:0] wa, wb, wr, acc;
    wa  = a;
    wb  = b;
    wr  = r;
    acc = (wa * ((128'sd1 <<< FracBits) - wr) + wb * wr) >>> FracBits;
    if (acc > ValMax) acc = ValMax;
    if (acc < ValMin) acc = ValMin;
    return acc[tlhm_pkg::OutW-1:0];
  endfunction

  // Value, first derivatives and mixed derivatives of one cell component.
  function automatic cell_result_t hex_map_predict(input cell_sample_t s);
    logic signed [63:0] c [8];
    cell_result_t res;
    for (int i = 0; i < 8; i++) c[i] = $signed(s.vert[i]);
    res.mapped_value = interp(interp(interp(c[0], c[1], s.u), interp(c[3], c[2], s.u), s.v),
                              interp(interp(c[4], c[5], s.u), interp(c[7], c[6], s.u), s.v),
                              s.w);
    res.deriv_u  = interp(interp(c[1] - c[0], c[2] - c[3], s.v),
                          interp(c[5] - c[4], c[6] - c[7], s.v), s.w);
    res.deriv_v  = interp(interp(c[3] - c[0], c[2] - c[1], s.u),
                          interp(c[7] - c[4], c[6] - c[5], s.u), s.w);
    res.deriv_w  = interp(interp(c[4] - c[0], c[5] - c[1], s.u),
                          interp(c[7] - c[3], c[6] - c[2], s.u), s.v);
    res.deriv_uv = interp(c[0] - c[1] + c[2] - c[3], c[4] - c[5] + c[6] - c[7], s.w);
    res.deriv_uw = interp(c[0] - c[1] - c[4] + c[5], c[3] - c[2] + c[6] - c[7], s.v);
    res.deriv_vw = interp(c[0] - c[3] - c[4] + c[7], c[1] - c[2] - c[5] + c[6], s.u);
    res.inside_cell = (s.u >= 0) && (s.u <= RefOne) && (s.v >= 0) && (s.v <= RefOne) &&
                      (s.w >= 0) && (s.w <= RefOne);
    return res;
  endfunction

  // Vertex values lean toward the extremes and small magnitudes.
  function automatic tlhm_pkg::tlhm_vert_t rand_vert();
    case ($urandom_range(0, 7))
      0:       return VertMax;
      1:       return VertMin;
      2:       return tlhm_pkg::tlhm_vert_t'($urandom_range(0, 2000)) - 1000;
      default: return tlhm_pkg::tlhm_vert_t'($urandom);
    endcase
  endfunction

  // Reference coordinate inside the unit range, or anywhere in the field.
  function automatic tlhm_pkg::tlhm_ref_t rand_ref(input bit in_cell);
    case ($urandom_range(0, 9))
      0:       return in_cell ? tlhm_pkg::tlhm_ref_t'(0) : RefMin;
      1:       return in_cell ? RefOne : RefMax;
      default: return in_cell ? tlhm_pkg::tlhm_ref_t'($urandom_range(0, 65536))
                              : tlhm_pkg::tlhm_ref_t'($urandom_range(0, 262143));
    endcase
  endfunction

  function automatic cell_sample_t random_sample(input bit in_cell);
    cell_sample_t s;
    for (int i = 0; i < 8; i++) s.vert[i] = rand_vert();
    s.u = rand_ref(in_cell);
    s.v = rand_ref(in_cell);
    s.w = rand_ref(in_cell);
    return s;
  endfunction

  // Offer one beat, wait for it to be taken, then maybe open a gap.
  task automatic push_sample(input cell_sample_t smp);
    s_axis_tdata  <= {{PadW{1'b0}}, smp};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(hex_map_predict(smp));
    if (!sender_gapless) begin
      if (burst_left == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120)
                                               : $urandom_range(1, 20);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Drop the valid and wait until every outstanding result has come back.
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Vertex i takes the maximum where bit i of the mask is set, else the minimum.
  task automatic send_pattern(input logic [7:0] hi_mask, input tlhm_pkg::tlhm_ref_t u,
                              input tlhm_pkg::tlhm_ref_t v, input tlhm_pkg::tlhm_ref_t w);
    cell_sample_t smp;
    for (int i = 0; i < 8; i++) smp.vert[i] = hi_mask[i] ? VertMax : VertMin;
    smp.u = u;
    smp.v = v;
    smp.w = w;
    push_sample(smp);
  endtask

  // At each cube corner the value must equal that vertex.
  task automatic test_cube_corners();
    cell_sample_t smp;
    for (int k = 0; k < 8; k++) begin
      smp   = random_sample(1'b1);
      smp.u = k[0] ? RefOne : tlhm_pkg::tlhm_ref_t'(0);
      smp.v = k[1] ? RefOne : tlhm_pkg::tlhm_ref_t'(0);
      smp.w = k[2] ? RefOne : tlhm_pkg::tlhm_ref_t'(0);
      push_sample(smp);
    end
  endtask

  // Extreme vertices, farthest extrapolation, and points just off the cube faces.
  task automatic test_field_extremes();
    cell_sample_t smp;
    send_pattern(8'hff, RefMin, RefMin, RefMin);
    send_pattern(8'hff, RefMax, RefMax, RefMax);
    send_pattern(8'h55, RefMin, RefMax, RefMin);
    send_pattern(8'haa, RefMax, RefMin, RefMax);
    send_pattern(8'ha5, RefMin, RefMin, RefMin);
    send_pattern(8'h5a, RefMax, RefMax, RefMax);
    send_pattern(8'h00, RefOne, RefOne, RefOne);
    send_pattern(8'h00, 18'sd0, 18'sd0, 18'sd0);
    smp   = random_sample(1'b1);
    smp.u = RefOne + 18'sd1;
    push_sample(smp);
    smp   = random_sample(1'b1);
    smp.v = -18'sd1;
    push_sample(smp);
    smp   = random_sample(1'b1);
    smp.w = RefOne + 18'sd1;
    push_sample(smp);
    smp      = random_sample(1'b0);
    smp.vert = '0;
    push_sample(smp);
  endtask

  task automatic test_random_in_cell(input int count);
    repeat (count) push_sample(random_sample(1'b1));
  endtask

  task automatic test_random_extrapolated(input int count);
    repeat (count) push_sample(random_sample($urandom_range(0, 3) == 0));
  endtask

  // Receiver holds off while the sender streams back to back, so the input stalls.
  task automatic test_output_holdoff();
    hold_request   = 300;
    sender_gapless = 1'b1;
    repeat (60) push_sample(random_sample(1'($urandom_range(0, 1))));
    sender_gapless = 1'b0;
  endtask

  // Sender goes quiet until the pipeline is empty, then resumes.
  task automatic test_pause_for_drain();
    repeat (40) push_sample(random_sample(1'($urandom_range(0, 1))));
    wait_for_drain();
    @(posedge clk_i);
    repeat (300) push_sample(random_sample(1'($urandom_range(0, 1))));
  endtask

  // Receiver: segments of random stall density, with an optional long hold-off.
  initial begin : sink_pattern
    int hold_left;
    int seg_left;
    int stall_pct;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(5, 60);
          case ($urandom_range(0, 4))
            0, 1:    stall_pct = 0;
            2:       stall_pct = 25;
            3:       stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end else begin
          seg_left--;
        end
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic check_field(input string name,
                             input logic signed [tlhm_pkg::OutW-1:0] want,
                             input logic signed [tlhm_pkg::OutW-1:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Compare every output beat with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    cell_result_t got;
    cell_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t ns: unexpected output beat, expected none, actual %h", $time, got);
      end else begin
        want = expected_results.pop_front();
        check_field("mapped_value", want.mapped_value, got.mapped_value);
        check_field("deriv_u", want.deriv_u, got.deriv_u);
        check_field("deriv_v", want.deriv_v, got.deriv_v);
        check_field("deriv_w", want.deriv_w, got.deriv_w);
        check_field("deriv_uv", want.deriv_uv, got.deriv_uv);
        check_field("deriv_uw", want.deriv_uw, got.deriv_uw);
        check_field("deriv_vw", want.deriv_vw, got.deriv_vw);
        check_field("inside_cell", {{(tlhm_pkg::OutW-1){1'b0}}, want.inside_cell},
                    {{(tlhm_pkg::OutW-1){1'b0}}, got.inside_cell});
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst_left = $urandom_range(1, 20);
    test_cube_corners();
    test_field_extremes();
    test_random_in_cell(600);
    test_random_extrapolated(430);
    test_output_holdoff();
    test_pause_for_drain();
    wait_for_drain();
    repeat (30) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> trilinear_hex_map_with_derivatives.f
sv/tlhm_pkg.sv
sv/tlhm_lerp.sv
sv/trilinear_hex_map_with_derivatives.sv
sv/tlhm_checker.sv
bench/testbench.sv
